// ----- hdl/tme_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tme_pkg
// shared types and constants for the tape machine execute stage
// ----------------------------------------------------------------------------
package tme_pkg;

  localparam int TAPE_DEPTH_DEF    = 65536;
  localparam int PROGRAM_DEPTH_DEF = 4096;

  localparam int MODE_W     = 4;
  localparam int REPEAT_W   = 16;
  localparam int ADDR_W     = 12;
  localparam int BYTE_W     = 8;

  // stream payload widths
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_END   = 4'h0,
    MODE_RIGHT = 4'h1,
    MODE_LEFT  = 4'h2,
    MODE_ADD   = 4'h3,
    MODE_SUB   = 4'h4,
    MODE_PUT   = 4'h5,
    MODE_GET   = 4'h6,
    MODE_OPEN  = 4'h7,
    MODE_CLOSE = 4'h8
  } mode_t;

endpackage
`default_nettype wire

// ----- hdl/tape_machine_execute.sv -----
`default_nettype none
// pipeline: an accepted instruction passes two register stages (tape read, then
//   result register) before its result shows on m_axis
// throughput: one instruction per cycle unless m_axis stalls or the tape clears;
//   one-write, one-read tape, read-modify-write for add and sub, write forwarding
// reset: synchronous; head and control clear at once, then a clearing pass
//   zeroes the tape while s_axis_tready stays low
// ----------------------------------------------------------------------------
// tape_machine_execute
// execute stage of a run-length-encoded eight-command tape machine
// ----------------------------------------------------------------------------
module tape_machine_execute
  import tme_pkg::*;
#(
  parameter int TAPE_DEPTH    = TAPE_DEPTH_DEF,
  parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  // extra_repeats[15:0], instr_address[27:16], jump_target[39:28], in_byte[47:40]
  input  wire  [IN_DATA_W-1:0]  s_axis_tdata,
  // mode[3:0]
  input  wire  [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  // next_address[11:0], out_byte[19:12], zero[23:20]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // put_valid[0], halted[1]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  localparam int AW = $clog2(TAPE_DEPTH);
  localparam int SUM_W = ADDR_W + 1;

  // reciprocal for the program address wrap
  localparam int RS = 26;
  localparam int RM_W = 23;
  localparam int PROD_W = SUM_W + RM_W;
  localparam int Q_W = PROD_W - RS;
  localparam int PD_W = 31;
  localparam logic [RM_W-1:0] RM = RM_W'((64'(1) << RS) / PROGRAM_DEPTH);
  localparam logic [PD_W-1:0] PD = PD_W'(PROGRAM_DEPTH);

  // tape memory
  logic [BYTE_W-1:0] tape [TAPE_DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;

  // clearing pass
  logic              clr_active;
  logic [AW-1:0]     clr_addr;

  logic [AW-1:0]     head;
  logic [AW-1:0]     head_next;

  // execute stage
  logic              s1_valid;
  mode_t             s1_mode;
  logic [AW-1:0]     s1_h;
  logic [BYTE_W-1:0] s1_byte;
  logic [ADDR_W-1:0] s1_addr;
  logic [SUM_W-1:0]  s1_sum_seq;
  logic [SUM_W-1:0]  s1_sum_tgt;
  logic [Q_W-1:0]    s1_q_seq;
  logic [Q_W-1:0]    s1_q_tgt;

  // last write, for the read that overlapped it
  logic              fwd_valid;
  logic [AW-1:0]     fwd_addr;
  logic [BYTE_W-1:0] fwd_data;

  logic              en;
  logic              accept;

  mode_t             in_mode;
  logic [REPEAT_W-1:0] in_rep;
  logic [ADDR_W-1:0] in_addr;
  logic [ADDR_W-1:0] in_tgt;
  logic [BYTE_W-1:0] in_byte;
  logic [REPEAT_W:0] in_count;
  logic [AW-1:0]     in_step;
  logic [SUM_W-1:0]  sum_seq;
  logic [SUM_W-1:0]  sum_tgt;
  logic [PROD_W-1:0] prod_seq;
  logic [PROD_W-1:0] prod_tgt;
  logic [BYTE_W-1:0] byte_sel;

  logic [BYTE_W-1:0] cur_byte;
  logic [PD_W-1:0]   rem_seq_raw;
  logic [PD_W-1:0]   rem_tgt_raw;
  logic [PD_W-1:0]   rem_seq;
  logic [PD_W-1:0]   rem_tgt;
  logic              s1_wr;
  logic [BYTE_W-1:0] s1_wdata;
  logic [ADDR_W-1:0] res_next;
  logic              res_put;
  logic [BYTE_W-1:0] res_byte;
  logic              res_halt;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !clr_active;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // input unpacking and early work
  assign in_mode  = mode_t'(s_axis_tuser[MODE_W-1:0]);
  assign in_rep   = s_axis_tdata[15:0];
  assign in_addr  = s_axis_tdata[27:16];
  assign in_tgt   = s_axis_tdata[39:28];
  assign in_byte  = s_axis_tdata[47:40];
  assign in_count = {1'b0, in_rep} + (REPEAT_W+1)'(1);
  assign in_step  = in_count[AW-1:0];
  assign sum_seq  = {1'b0, in_addr} + SUM_W'(1);
  assign sum_tgt  = {1'b0, in_tgt} + SUM_W'(1);
  assign prod_seq = PROD_W'(sum_seq) * PROD_W'(RM);
  assign prod_tgt = PROD_W'(sum_tgt) * PROD_W'(RM);

  always_comb begin
    head_next = head;
    byte_sel  = in_byte;
    case (in_mode)
      MODE_RIGHT: head_next = head + in_step;
      MODE_LEFT:  head_next = head - in_step;
      MODE_ADD:   byte_sel  = in_count[BYTE_W-1:0];
      MODE_SUB:   byte_sel  = ~in_rep[BYTE_W-1:0];
      default:    head_next = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (accept) begin
      head <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode    <= in_mode;
      s1_h       <= head;
      s1_byte    <= byte_sel;
      s1_addr    <= in_addr;
      s1_sum_seq <= sum_seq;
      s1_sum_tgt <= sum_tgt;
      s1_q_seq   <= prod_seq[PROD_W-1:RS];
      s1_q_tgt   <= prod_tgt[PROD_W-1:RS];
    end
  end

  // tape read and write ports
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= tape[head];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      tape[waddr] <= wdata;
    end
  end

  always_comb begin
    if (clr_active) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = en && s1_valid && s1_wr;
      waddr = s1_h;
      wdata = s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == {AW{1'b1}}) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (en) begin
      fwd_valid <= s1_valid && s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_addr <= s1_h;
      fwd_data <= s1_wdata;
    end
  end

  // execute: cell value, wrapped addresses, result
  assign cur_byte = (fwd_valid && fwd_addr == s1_h) ? fwd_data : rdata;

  assign rem_seq_raw = PD_W'(s1_sum_seq) - PD_W'(s1_q_seq) * PD;
  assign rem_tgt_raw = PD_W'(s1_sum_tgt) - PD_W'(s1_q_tgt) * PD;
  assign rem_seq = (rem_seq_raw >= PD) ? rem_seq_raw - PD : rem_seq_raw;
  assign rem_tgt = (rem_tgt_raw >= PD) ? rem_tgt_raw - PD : rem_tgt_raw;

  always_comb begin
    s1_wr    = 1'b0;
    s1_wdata = cur_byte + s1_byte;
    res_next = rem_seq[ADDR_W-1:0];
    res_put  = 1'b0;
    res_byte = '0;
    res_halt = 1'b0;
    case (s1_mode)
      MODE_END: begin
        res_halt = 1'b1;
        res_next = s1_addr;
      end
      MODE_ADD, MODE_SUB: begin
        s1_wr = 1'b1;
      end
      MODE_GET: begin
        s1_wr    = 1'b1;
        s1_wdata = s1_byte;
      end
      MODE_PUT: begin
        res_put  = 1'b1;
        res_byte = cur_byte;
      end
      MODE_OPEN: begin
        if (cur_byte == '0) begin
          res_next = rem_tgt[ADDR_W-1:0];
        end
      end
      MODE_CLOSE: begin
        if (cur_byte != '0) begin
          res_next = rem_tgt[ADDR_W-1:0];
        end
      end
      default: begin
        s1_wr = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      m_axis_tdata <= {4'b0, res_byte, res_next};
      m_axis_tuser <= {res_halt, res_put};
    end
  end

  // checks
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_axis_tready)
    else $error("instruction taken during tape clearing");

  a_no_work_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> (!s1_valid && !fwd_valid))
    else $error("execute stage busy during tape clearing");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("output and halt flagged together");

  a_head_still: assert property (@(posedge clk) disable iff (rst)
    !accept |=> head == $past(head))
    else $error("head moved without an instruction");

  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && en) |=> m_axis_tvalid)
    else $error("executed instruction lost before result register");

endmodule
`default_nettype wire
